// File: rtl/core/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int POOL_WORDS = 16384;
  localparam int AW         = $clog2(POOL_WORDS);
  localparam int HDR_WORDS  = 2;
  // header size word: in-use flag above the payload size in words
  localparam int SIZE_W     = AW + 1;

  localparam logic [AW-1:0] POOL_FREE_SIZE = AW'(POOL_WORDS - HDR_WORDS);
  localparam logic [10:0]   SLACK_RESET    = 11'd4;
  localparam logic [10:0]   SLACK_MIN      = 11'(HDR_WORDS);

  typedef logic [AW-1:0] addr_t;
  typedef logic [15:0]   words_t;

  typedef struct packed {
    logic              size_we;
    logic              link_we;
    addr_t             waddr;
    logic [SIZE_W-1:0] size_wdata;
    addr_t             link_wdata;
    addr_t             raddr;
  } mem_req_t;

  typedef struct packed {
    logic        granted;
    logic [13:0] payload_index;
    logic [16:0] rounded_request_bytes;
    logic [16:0] largest_free_bytes;
    logic [16:0] total_free_bytes;
  } result_t;

endpackage

// File: rtl/core/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: walks the header chain, grants or splits a block, and on
// refusal makes a second pass summing the free space.
// ----------------------------------------------------------------------------
module ffba_ctrl import ffba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [16:0]       request_bytes,
  input  logic              cfg_wr_en,
  input  logic [10:0]       cfg_wr_data,
  input  logic [SIZE_W-1:0] size_rdata,
  input  addr_t             link_rdata,
  output mem_req_t          mem_req,
  input  logic              res_free,
  output logic              res_load,
  output result_t           res
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FETCH    = 3'd1;
  localparam logic [2:0] S_EVAL     = 3'd2;
  localparam logic [2:0] S_SPLIT_LO = 3'd3;
  localparam logic [2:0] S_SPLIT_HI = 3'd4;
  localparam logic [2:0] S_SCAN     = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]  state;
  addr_t       h;
  words_t      words;
  logic [10:0] slack_cfg;
  logic        size0_ok;
  logic        link0_ok;
  addr_t       nh;
  addr_t       link_hold;
  addr_t       new_size;
  logic        granted_r;
  logic [13:0] payload_r;
  addr_t       max_size;
  logic [AW:0] total_free;

  logic        cur_flag;
  addr_t       cur_size;
  addr_t       cur_link;
  logic [10:0] slack_eff;
  logic        fits;
  addr_t       left;
  logic        split;
  addr_t       nh_calc;
  logic [17:0] bytes_up;
  words_t      words_calc;

  // entry 0 holds the reset header until the first write there
  always_comb begin
    if (h == '0 && !size0_ok) begin
      cur_flag = 1'b0;
      cur_size = POOL_FREE_SIZE;
    end else begin
      cur_flag = size_rdata[SIZE_W-1];
      cur_size = size_rdata[AW-1:0];
    end
    cur_link = (h == '0 && !link0_ok) ? '0 : link_rdata;
  end

  assign slack_eff  = (slack_cfg < SLACK_MIN) ? SLACK_MIN : slack_cfg;
  assign fits       = !cur_flag && (words <= words_t'(cur_size));
  assign left       = cur_size - AW'(words);
  assign split      = left >= AW'(slack_eff);
  assign nh_calc    = h + AW'(HDR_WORDS) + AW'(words);
  assign bytes_up   = {1'b0, request_bytes}
                    + ((request_bytes[1:0] != 2'b00) ? 18'd4 : 18'd0);
  assign words_calc = bytes_up[17:2];

  assign in_ready = (state == S_IDLE);
  assign res_load = (state == S_DONE) && res_free;

  always_comb begin
    res.granted               = granted_r;
    res.payload_index         = payload_r;
    res.rounded_request_bytes = 17'({words, 2'b00});
    res.largest_free_bytes    = granted_r ? 17'd0 : 17'({max_size, 2'b00});
    res.total_free_bytes      = granted_r ? 17'd0 : 17'({total_free, 2'b00});
  end

  always_comb begin
    mem_req            = '0;
    mem_req.raddr      = h;
    mem_req.waddr      = h;
    case (state)
      S_EVAL: begin
        mem_req.raddr = cur_link;
        if (fits && !split) begin
          mem_req.size_we    = 1'b1;
          mem_req.size_wdata = {1'b1, cur_size};
        end
      end
      S_SCAN: begin
        mem_req.raddr = cur_link;
      end
      S_SPLIT_LO: begin
        // new free header after the granted payload
        mem_req.size_we    = 1'b1;
        mem_req.link_we    = 1'b1;
        mem_req.waddr      = nh;
        mem_req.size_wdata = {1'b0, new_size};
        mem_req.link_wdata = link_hold;
      end
      S_SPLIT_HI: begin
        mem_req.size_we    = 1'b1;
        mem_req.link_we    = 1'b1;
        mem_req.size_wdata = {1'b1, AW'(words)};
        mem_req.link_wdata = nh;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      size0_ok  <= 1'b0;
      link0_ok  <= 1'b0;
      slack_cfg <= SLACK_RESET;
    end else begin
      if (cfg_wr_en) begin
        slack_cfg <= cfg_wr_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            h     <= '0;
            words <= words_calc;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (fits) begin
            granted_r <= 1'b1;
            payload_r <= 14'(h + AW'(HDR_WORDS));
            if (split) begin
              nh        <= nh_calc;
              link_hold <= cur_link;
              new_size  <= left - AW'(HDR_WORDS);
              state     <= S_SPLIT_LO;
            end else begin
              if (h == '0) begin
                size0_ok <= 1'b1;
              end
              state <= S_DONE;
            end
          end else if (cur_link == '0) begin
            // refused: rescan from the head for the free totals
            granted_r  <= 1'b0;
            payload_r  <= '0;
            max_size   <= '0;
            total_free <= '0;
            h          <= '0;
            state      <= S_SCAN;
          end else begin
            h <= cur_link;
          end
        end
        S_SPLIT_LO: begin
          state <= S_SPLIT_HI;
        end
        S_SPLIT_HI: begin
          if (h == '0) begin
            size0_ok <= 1'b1;
            link0_ok <= 1'b1;
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          if (!cur_flag) begin
            if (cur_size > max_size) begin
              max_size <= cur_size;
            end
            total_free <= total_free + (AW+1)'(cur_size);
          end
          if (cur_link == '0) begin
            state <= S_DONE;
          end else begin
            h <= cur_link;
          end
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/ffba_out.sv
// ----------------------------------------------------------------------------
// ffba_out
// Output register holding one result until the receiver takes it.
// ----------------------------------------------------------------------------
module ffba_out import ffba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        granted,
  output logic [13:0] payload_index,
  output logic [16:0] rounded_request_bytes,
  output logic [16:0] largest_free_bytes,
  output logic [16:0] total_free_bytes
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      granted               <= res.granted;
      payload_index         <= res.payload_index;
      rounded_request_bytes <= res.rounded_request_bytes;
      largest_free_bytes    <= res.largest_free_bytes;
      total_free_bytes      <= res.total_free_bytes;
    end
  end

endmodule

// File: rtl/core/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator with block splitting over a 16K-word pool.
// ----------------------------------------------------------------------------
// request channel: in_valid/in_ready with request_bytes; one request is
//   worked on at a time, in_ready is high only while the sequencer is idle
// result channel: out_valid/out_ready with granted, payload_index,
//   rounded_request_bytes, largest_free_bytes and total_free_bytes
// config: cfg_wr_en/cfg_wr_data write min_split_slack, no handshake
// walk: the chain walk visits one header a cycle out of the header rams;
//   a grant goes through fetch, eval at each header, then done before the result
//   register load, with split-low and split-high in between when split; a
//   refusal adds a second whole-chain walk, one header a cycle, for free totals
// next request: taken the cycle after the result is loaded
// reset: the pool is one free block over the whole memory; header 0 reads as
//   that block until first written, so no clearing pass is needed
// stall: a result waits in the output register while the next request is
//   walked; the sequencer holds in its done state only if the register
//   is still full
// ----------------------------------------------------------------------------
module first_fit_block_allocator import ffba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [16:0] request_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        granted,
  output logic [13:0] payload_index,
  output logic [16:0] rounded_request_bytes,
  output logic [16:0] largest_free_bytes,
  output logic [16:0] total_free_bytes,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data
);

  mem_req_t          mem_req;
  logic [SIZE_W-1:0] size_rdata;
  addr_t             link_rdata;
  logic              res_free;
  logic              res_load;
  result_t           res;

  ffba_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .request_bytes (request_bytes),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .size_rdata    (size_rdata),
    .link_rdata    (link_rdata),
    .mem_req       (mem_req),
    .res_free      (res_free),
    .res_load      (res_load),
    .res           (res)
  );

  // header size words, keyed by header index
  ffba_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (POOL_WORDS)
  ) u_size_ram (
    .clk   (clk),
    .we    (mem_req.size_we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.size_wdata),
    .raddr (mem_req.raddr),
    .rdata (size_rdata)
  );

  // header next links, keyed by header index
  ffba_ram #(
    .WIDTH (AW),
    .DEPTH (POOL_WORDS)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_req.link_we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.link_wdata),
    .raddr (mem_req.raddr),
    .rdata (link_rdata)
  );

  ffba_out u_out (
    .clk                   (clk),
    .rst                   (rst),
    .load                  (res_load),
    .res                   (res),
    .free                  (res_free),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .granted               (granted),
    .payload_index         (payload_index),
    .rounded_request_bytes (rounded_request_bytes),
    .largest_free_bytes    (largest_free_bytes),
    .total_free_bytes      (total_free_bytes)
  );

endmodule

// File: tb/sv/first_fit_block_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_test
// Self-checking test of the first-fit block allocator. A model of the word
// pool and its header chain predicts every grant or refusal. A directed
// opening covers rounding, zero-byte, full-width and wrapping requests. Random
// phases then run under different split slacks, with request sizes paced so
// that the pool fills late in the run. A short tail drives the pool to
// exhaustion through an empty free block.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_test import ffba_pkg::*;;

  localparam int unsigned IN_USE    = 32'h8000_0000;
  localparam int unsigned SIZE_BITS = 32'h7fff_ffff;
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 105;
  localparam int          LONG_HOLD_AT = 150;
  localparam int          LONG_HOLD    = 600;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [16:0] request_bytes = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        granted;
  logic [13:0] payload_index;
  logic [16:0] rounded_request_bytes;
  logic [16:0] largest_free_bytes;
  logic [16:0] total_free_bytes;
  logic        cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;

  // model of the pool and the slack register
  int unsigned pool_mem [POOL_WORDS];
  int unsigned split_slack;

  logic [16:0] pending_req [$];
  result_t     expected_res [$];
  int unsigned req_pushed = 0;
  int unsigned res_seen = 0;
  int unsigned err_count = 0;
  bit          steady = 1'b0;
  bit          long_hold_done = 1'b0;
  int          send_gap;
  int          hold_left;

  first_fit_block_allocator uut (
    .clk                   (clk),
    .rst                   (rst),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .request_bytes         (request_bytes),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .granted               (granted),
    .payload_index         (payload_index),
    .rounded_request_bytes (rounded_request_bytes),
    .largest_free_bytes    (largest_free_bytes),
    .total_free_bytes      (total_free_bytes),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // largest free payload and sum of free payloads, in words
  function automatic void free_scan(output int unsigned max_w, output longint unsigned sum_w);
    int unsigned h, steps, hw;
    max_w = 0;
    sum_w = 0;
    h = 0;
    steps = 0;
    while (h + HDR_WORDS <= POOL_WORDS && steps < POOL_WORDS) begin
      hw = pool_mem[h];
      if ((hw & IN_USE) == 0) begin
        if (max_w < (hw & SIZE_BITS)) max_w = hw & SIZE_BITS;
        sum_w += hw & SIZE_BITS;
      end
      if (pool_mem[h + 1] == 0) break;
      h = pool_mem[h + 1];
      steps++;
    end
  endfunction

  function automatic result_t alloc_predict(input logic [16:0] req);
    result_t         r;
    int unsigned     bytes, words, slack, h, steps, hw, nxt, left, nh, max_w;
    longint unsigned sum_w;
    bit              ok;
    r = '0;
    ok = 1'b0;
    h = 0;
    steps = 0;
    bytes = req;
    slack = (split_slack < HDR_WORDS) ? HDR_WORDS : split_slack;
    // round up by adding a word and dropping the byte bits
    if ((bytes & 3) != 0) bytes += 4;
    words = bytes >> 2;
    while (h + HDR_WORDS <= POOL_WORDS && steps < POOL_WORDS) begin
      hw  = pool_mem[h];
      nxt = pool_mem[h + 1];
      if ((hw & IN_USE) == 0 && words <= hw) begin
        left = hw - words;
        if (left < slack) begin
          pool_mem[h] = hw | IN_USE;
        end else begin
          nh = h + HDR_WORDS + words;
          pool_mem[nh]     = left - HDR_WORDS;
          pool_mem[nh + 1] = nxt;
          pool_mem[h]      = words | IN_USE;
          pool_mem[h + 1]  = nh;
        end
        ok = 1'b1;
        r.payload_index = 14'(h + HDR_WORDS);
        break;
      end
      if (nxt == 0) break;
      h = nxt;
      steps++;
    end
    r.granted = ok;
    r.rounded_request_bytes = 17'(words << 2);
    if (!ok) begin
      free_scan(max_w, sum_w);
      r.largest_free_bytes = 17'(max_w << 2);
      r.total_free_bytes   = 17'(sum_w << 2);
    end
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  task automatic push_req(input logic [16:0] b);
    pending_req.push_back(b);
    req_pushed++;
  endtask

  task automatic wait_drained();
    wait (res_seen == req_pushed);
    @(posedge clk);
  endtask

  task automatic write_slack(input logic [10:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    split_slack = v;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) expected_res.push_back(alloc_predict(request_bytes));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_req.size() > 0) begin
          in_valid      <= 1'b1;
          request_bytes <= pending_req.pop_front();
          send_gap      <= steady ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    result_t want;
    int      g;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_res.size() == 0) begin
          $error("result transfer with no request outstanding");
          err_count++;
        end else begin
          want = expected_res.pop_front();
          check_field("granted", want.granted, granted);
          check_field("payload_index", want.payload_index, payload_index);
          check_field("rounded_request_bytes", want.rounded_request_bytes,
                      rounded_request_bytes);
          check_field("largest_free_bytes", want.largest_free_bytes, largest_free_bytes);
          check_field("total_free_bytes", want.total_free_bytes, total_free_bytes);
        end
        res_seen++;
      end
      // one long hold-off so that the block backs up onto its request side
      if (!long_hold_done && res_seen == LONG_HOLD_AT) begin
        long_hold_done <= 1'b1;
        out_ready      <= 1'b0;
        hold_left      <= LONG_HOLD;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else begin
        g = steady ? 0 : idle_len();
        out_ready <= (g == 0);
        hold_left <= (g > 0) ? g - 1 : 0;
      end
    end
  end

  initial begin
    int unsigned     max_w, free_w, mean_b, r;
    longint unsigned sum_w;
    int unsigned     slack_plan [PHASES];
    slack_plan = '{1024, 2047, 0, 2, 1, 4, 0, 16};
    slack_plan[6] = $urandom_range(3, 64);
    for (int i = 0; i < POOL_WORDS; i++) pool_mem[i] = 0;
    pool_mem[0] = POOL_WORDS - HDR_WORDS;
    split_slack = SLACK_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // zero-byte, rounding, full-width and wrapping requests
    push_req(17'd0);
    push_req(17'd1);
    push_req(17'd2);
    push_req(17'd3);
    push_req(17'd4);
    push_req(17'd5);
    push_req(17'd7);
    push_req(17'd8);
    push_req(17'd100);
    push_req(17'd1023);
    push_req(17'd1024);
    push_req(17'd4096);
    push_req(17'd65535);
    push_req(17'd65536);
    push_req(17'd131068);
    push_req(17'd131071);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_slack(11'(slack_plan[p]));
      steady = (p == 5);
      free_scan(max_w, sum_w);
      free_w = max_w;
      // pace sizes so the remaining free space lasts roughly to the end
      mean_b = free_w * 4 / ((PHASES - p) * PHASE_ITEMS);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 80) push_req(17'($urandom_range(0, 2 * mean_b + 8)));
        else if (r < 92) push_req(17'($urandom_range(0, 16)));
        else if (r < 97) push_req(17'($urandom_range(free_w * 4 + 1, 131071)));
        else push_req(17'($urandom_range(0, 4 * (free_w / 16 + 1))));
      end
    end

    // leftover equal to the slack leaves an empty free block behind
    wait_drained();
    write_slack(SLACK_MIN);
    steady = 1'b0;
    free_scan(max_w, sum_w);
    if (max_w >= HDR_WORDS) push_req(17'((max_w - HDR_WORDS) * 4));
    push_req(17'd4);
    push_req(17'd0);
    push_req(17'd0);

    wait_drained();
    repeat (64) @(posedge clk);
    if (expected_res.size() != 0) begin
      $error("%0d results never arrived", expected_res.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("first_fit_block_allocator regression: pass");
    end else begin
      $display("first_fit_block_allocator regression: fail");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("first_fit_block_allocator regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ffba_pkg.sv
rtl/core/ffba_ram.sv
rtl/core/ffba_ctrl.sv
rtl/core/ffba_out.sv
rtl/core/first_fit_block_allocator.sv
tb/sv/first_fit_block_allocator_test.sv
